// ===== design/cfsp_pkg.sv =====
package cfsp_pkg;

    typedef enum logic [4:0] {
        S_MAGIC  = 5'd0,
        S_MINOR  = 5'd1,
        S_MAJOR  = 5'd2,
        S_PCOUNT = 5'd3,
        S_PTAG   = 5'd4,
        S_PBODY  = 5'd5,
        S_ACCESS = 5'd6,
        S_THIS   = 5'd7,
        S_SUPER  = 5'd8,
        S_ICOUNT = 5'd9,
        S_IFACE  = 5'd10,
        S_FCOUNT = 5'd11,
        S_FHDR   = 5'd12,
        S_FAHDR  = 5'd13,
        S_FABODY = 5'd14,
        S_MCOUNT = 5'd15,
        S_MHDR   = 5'd16,
        S_MAHDR  = 5'd17,
        S_MABODY = 5'd18,
        S_CCOUNT = 5'd19,
        S_CAHDR  = 5'd20,
        S_CABODY = 5'd21,
        S_END    = 5'd22
    } section_t;

    localparam logic [7:0] TAG_UTF8   = 8'd1;
    localparam logic [7:0] TAG_LONG   = 8'd5;
    localparam logic [7:0] TAG_DOUBLE = 8'd6;

    typedef struct packed {
        section_t    section;
        logic [15:0] entry_index;
        logic [7:0]  pool_tag;
        logic        value_done;
        logic [31:0] value;
        logic        file_done;
        logic        parse_error;
    } result_t;

    function automatic logic [3:0] fixed_body(input logic [7:0] tag);
        logic [3:0] len;
        begin
            unique case (tag)
                8'd7, 8'd8, 8'd16, 8'd19, 8'd20:                   len = 4'd2;
                8'd15:                                             len = 4'd3;
                8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12, 8'd17, 8'd18: len = 4'd4;
                8'd5, 8'd6:                                        len = 4'd8;
                default:                                           len = 4'd0;
            endcase
            return len;
        end
    endfunction

endpackage

// ===== design/cfsp_core.sv =====
module cfsp_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             advance,
    input  logic [7:0]       data_byte,
    input  logic             start_of_file,
    output cfsp_pkg::result_t res
);

    cfsp_pkg::section_t sec_reg, sec_next, sec;
    logic [2:0]  bii_reg, bii_next, bii;
    logic [31:0] vs_reg, vs_next, vs;
    logic [15:0] pc_reg, pc_next, pc;
    logic [15:0] pi_reg, pi_next, pi;
    logic [7:0]  tag_reg, tag_next, tagc;
    logic [31:0] br_reg, br_next, br;
    logic [15:0] oc_reg, oc_next, oc;
    logic [15:0] oi_reg, oi_next, oi;
    logic [15:0] ac_reg, ac_next, ac;
    logic [15:0] ai_reg, ai_next, ai;
    logic        err_reg, err_next, err;

    logic [3:0]  c;
    logic [3:0]  fb;
    logic [15:0] v16;
    logic [15:0] oi_inc;
    logic [15:0] ai_inc;
    logic [16:0] pool_n;
    logic        do_pool;
    logic [1:0]  pool_step;
    logic        do_attr_start;
    logic        do_attr_next;
    logic        attr_empty;
    cfsp_pkg::section_t ahdr;

    always_comb
    begin
        sec  = start_of_file ? cfsp_pkg::S_MAGIC : sec_reg;
        bii  = start_of_file ? 3'd0  : bii_reg;
        vs   = start_of_file ? 32'd0 : vs_reg;
        pc   = start_of_file ? 16'd0 : pc_reg;
        pi   = start_of_file ? 16'd1 : pi_reg;
        tagc = start_of_file ? 8'd0  : tag_reg;
        br   = start_of_file ? 32'd0 : br_reg;
        oc   = start_of_file ? 16'd0 : oc_reg;
        oi   = start_of_file ? 16'd0 : oi_reg;
        ac   = start_of_file ? 16'd0 : ac_reg;
        ai   = start_of_file ? 16'd0 : ai_reg;
        err  = start_of_file ? 1'b0  : err_reg;
    end

    always_comb
    begin
        vs_next  = (sec != cfsp_pkg::S_END) ? {vs[23:0], data_byte} : vs;
        v16      = vs_next[15:0];
        sec_next = sec;
        bii_next = bii;
        pc_next  = pc;
        pi_next  = pi;
        tag_next = tagc;
        br_next  = br;
        oc_next  = oc;
        oi_next  = oi;
        ac_next  = ac;
        ai_next  = ai;
        err_next = err;

        c        = {1'b0, bii} + 4'd1;
        fb       = cfsp_pkg::fixed_body(data_byte);
        oi_inc   = oi + 16'd1;
        ai_inc   = ai + 16'd1;
        do_pool  = 1'b0;
        pool_step = 2'd1;
        do_attr_start = 1'b0;
        do_attr_next  = 1'b0;
        ahdr     = cfsp_pkg::S_CAHDR;
        pool_n   = 17'd0;
        attr_empty = 1'b0;

        res.section     = sec;
        res.entry_index = 16'd0;
        res.pool_tag    = 8'd0;
        res.value_done  = 1'b0;
        res.value       = 32'd0;
        res.file_done   = 1'b0;

        unique case (sec)
            cfsp_pkg::S_MAGIC:
            begin
                if (c >= 4'd4)
                begin
                    res.value_done = 1'b1;
                    res.value = vs_next;
                    bii_next = 3'd0;
                    sec_next = cfsp_pkg::S_MINOR;
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_MINOR, cfsp_pkg::S_MAJOR, cfsp_pkg::S_ACCESS,
            cfsp_pkg::S_THIS, cfsp_pkg::S_SUPER:
            begin
                if (c >= 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                    bii_next = 3'd0;
                    sec_next = cfsp_pkg::section_t'(sec + 5'd1);
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_PCOUNT:
            begin
                if (c >= 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                    bii_next = 3'd0;
                    pc_next = v16;
                    pi_next = 16'd1;
                    sec_next = (v16 <= 16'd1) ? cfsp_pkg::S_ACCESS : cfsp_pkg::S_PTAG;
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_PTAG:
            begin
                res.entry_index = pi;
                res.pool_tag = data_byte;
                tag_next = data_byte;
                if (data_byte == cfsp_pkg::TAG_UTF8)
                begin
                    br_next = 32'd0;
                    bii_next = 3'd0;
                    sec_next = cfsp_pkg::S_PBODY;
                end
                else if (fb == 4'd0)
                begin
                    err_next = 1'b1;
                    do_pool = 1'b1;
                end
                else
                begin
                    br_next = {28'd0, fb};
                    bii_next = 3'd2;
                    sec_next = cfsp_pkg::S_PBODY;
                end
            end
            cfsp_pkg::S_PBODY:
            begin
                res.entry_index = pi;
                res.pool_tag = tagc;
                if (bii < 3'd2)
                begin
                    if (c == 4'd2)
                    begin
                        res.value_done = 1'b1;
                        res.value = {16'd0, v16};
                        br_next = {16'd0, v16};
                        bii_next = 3'd2;
                        do_pool = (v16 == 16'd0);
                    end
                    else
                        bii_next = c[2:0];
                end
                else if (br <= 32'd1)
                begin
                    br_next = 32'd0;
                    do_pool = 1'b1;
                    pool_step = (tagc == cfsp_pkg::TAG_LONG || tagc == cfsp_pkg::TAG_DOUBLE)
                                ? 2'd2 : 2'd1;
                end
                else
                    br_next = br - 32'd1;
            end
            cfsp_pkg::S_ICOUNT, cfsp_pkg::S_FCOUNT, cfsp_pkg::S_MCOUNT:
            begin
                if (c >= 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                    bii_next = 3'd0;
                    oc_next = v16;
                    oi_next = 16'd0;
                    sec_next = (v16 == 16'd0)
                               ? cfsp_pkg::section_t'(sec + 5'd2)
                               : cfsp_pkg::section_t'(sec + 5'd1);
                    if (sec == cfsp_pkg::S_ICOUNT && v16 == 16'd0)
                        sec_next = cfsp_pkg::S_FCOUNT;
                    if (sec == cfsp_pkg::S_FCOUNT && v16 == 16'd0)
                        sec_next = cfsp_pkg::S_MCOUNT;
                    if (sec == cfsp_pkg::S_MCOUNT && v16 == 16'd0)
                        sec_next = cfsp_pkg::S_CCOUNT;
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_IFACE:
            begin
                res.entry_index = oi;
                if (c >= 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                    bii_next = 3'd0;
                    oi_next = oi_inc;
                    if (oi_inc >= oc)
                        sec_next = cfsp_pkg::S_FCOUNT;
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_CCOUNT:
            begin
                if (c >= 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                    bii_next = 3'd0;
                    do_attr_start = 1'b1;
                    ahdr = cfsp_pkg::S_CAHDR;
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_FHDR, cfsp_pkg::S_MHDR:
            begin
                res.entry_index = oi;
                if (!c[0])
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                end
                if (c >= 4'd8)
                begin
                    bii_next = 3'd0;
                    do_attr_start = 1'b1;
                    ahdr = cfsp_pkg::section_t'(sec + 5'd1);
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_FAHDR, cfsp_pkg::S_MAHDR, cfsp_pkg::S_CAHDR:
            begin
                res.entry_index = ai;
                if (c == 4'd2)
                begin
                    res.value_done = 1'b1;
                    res.value = {16'd0, v16};
                end
                if (c >= 4'd6)
                begin
                    res.value_done = 1'b1;
                    res.value = vs_next;
                    bii_next = 3'd0;
                    br_next = vs_next;
                    ahdr = sec;
                    if (vs_next == 32'd0)
                        do_attr_next = 1'b1;
                    else
                        sec_next = cfsp_pkg::section_t'(sec + 5'd1);
                end
                else
                    bii_next = c[2:0];
            end
            cfsp_pkg::S_FABODY, cfsp_pkg::S_MABODY, cfsp_pkg::S_CABODY:
            begin
                res.entry_index = ai;
                ahdr = cfsp_pkg::section_t'(sec - 5'd1);
                if (br <= 32'd1)
                begin
                    br_next = 32'd0;
                    do_attr_next = 1'b1;
                end
                else
                    br_next = br - 32'd1;
            end
            default:
            begin
                res.section = cfsp_pkg::S_END;
                sec_next = cfsp_pkg::S_END;
            end
        endcase

        if (do_pool)
        begin
            pool_n = {1'b0, pi} + {15'd0, pool_step};
            bii_next = 3'd0;
            pi_next = pool_n[15:0];
            if (pool_n >= {1'b0, pc})
            begin
                sec_next = cfsp_pkg::S_ACCESS;
                tag_next = 8'd0;
            end
            else
                sec_next = cfsp_pkg::S_PTAG;
        end

        if (do_attr_start)
        begin
            ac_next = v16;
            ai_next = 16'd0;
            attr_empty = (v16 == 16'd0);
        end
        else if (do_attr_next)
        begin
            ai_next = ai_inc;
            attr_empty = (ai_inc >= ac);
        end

        if (do_attr_start || do_attr_next)
        begin
            if (!attr_empty)
                sec_next = ahdr;
            else if (ahdr == cfsp_pkg::S_CAHDR)
            begin
                sec_next = cfsp_pkg::S_END;
                res.file_done = 1'b1;
            end
            else
            begin
                oi_next = oi_inc;
                if (ahdr == cfsp_pkg::S_MAHDR)
                    sec_next = (oi_inc >= oc) ? cfsp_pkg::S_CCOUNT : cfsp_pkg::S_MHDR;
                else
                    sec_next = (oi_inc >= oc) ? cfsp_pkg::S_MCOUNT : cfsp_pkg::S_FHDR;
            end
        end

        res.parse_error = err_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sec_reg <= cfsp_pkg::S_MAGIC;
            bii_reg <= 3'd0;
            vs_reg  <= 32'd0;
            pc_reg  <= 16'd0;
            pi_reg  <= 16'd1;
            tag_reg <= 8'd0;
            br_reg  <= 32'd0;
            oc_reg  <= 16'd0;
            oi_reg  <= 16'd0;
            ac_reg  <= 16'd0;
            ai_reg  <= 16'd0;
            err_reg <= 1'b0;
        end
        else if (advance)
        begin
            sec_reg <= sec_next;
            bii_reg <= bii_next;
            vs_reg  <= vs_next;
            pc_reg  <= pc_next;
            pi_reg  <= pi_next;
            tag_reg <= tag_next;
            br_reg  <= br_next;
            oc_reg  <= oc_next;
            oi_reg  <= oi_next;
            ac_reg  <= ac_next;
            ai_reg  <= ai_next;
            err_reg <= err_next;
        end
    end

endmodule

// ===== design/class_file_stream_parser_unit.sv =====
// Java class file stream parser.
// Input channel: data_byte and start_of_file with data_valid / data_ready.
// Each transfer carries one byte of the class file; start_of_file restarts
// parsing with that byte as the first magic byte and clears the error flag.
// Output channel: one result per input byte with result_valid / result_ready:
// section, entry_index, pool_tag, value_done and value (a completed big-endian
// u2 or u4), file_done and the sticky parse_error.
// Latency: the result of a byte is valid in the cycle after its transfer.
// Throughput: one byte per clock when not stalled; the per-byte parse step is
// one pass of logic from the parse state registers into the result register.
// Stall: while a result waits, data_ready stays high if result_ready is high
// in that cycle, so a taken result and a new byte move on the same edge;
// otherwise the result and the parse state hold.
// Reset: rst_n clears the parse state to the start of a file and empties
// the result register.
module class_file_stream_parser_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    output logic        result_valid,
    input  logic        result_ready,
    output logic [4:0]  section,
    output logic [15:0] entry_index,
    output logic [7:0]  pool_tag,
    output logic        value_done,
    output logic [31:0] value,
    output logic        file_done,
    output logic        parse_error
);

    logic              accept;
    logic              valid_reg, valid_next;
    cfsp_pkg::result_t step_res;
    cfsp_pkg::result_t res_reg;

    assign data_ready = !valid_reg || result_ready;
    assign accept     = data_valid && data_ready;
    assign valid_next = accept || (valid_reg && !result_ready);

    cfsp_core u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .advance       (accept),
        .data_byte     (data_byte),
        .start_of_file (start_of_file),
        .res           (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            res_reg <= step_res;
    end

    assign result_valid = valid_reg;
    assign section      = res_reg.section;
    assign entry_index  = res_reg.entry_index;
    assign pool_tag     = res_reg.pool_tag;
    assign value_done   = res_reg.value_done;
    assign value        = res_reg.value;
    assign file_done    = res_reg.file_done;
    assign parse_error  = res_reg.parse_error;

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !value_done |-> value == 32'd0)
        else $error("value nonzero without value_done");

    a_end_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && section == cfsp_pkg::S_END |->
            entry_index == 16'd0 && pool_tag == 8'd0 && !value_done && !file_done)
        else $error("past-end result carries data");

    a_tag_in_pool: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && pool_tag != 8'd0 |->
            section == cfsp_pkg::S_PTAG || section == cfsp_pkg::S_PBODY)
        else $error("pool tag outside constant pool");

    a_done_place: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && file_done |->
            section == cfsp_pkg::S_CCOUNT || section == cfsp_pkg::S_CAHDR
            || section == cfsp_pkg::S_CABODY)
        else $error("file_done outside class attributes");

endmodule

// ===== bench/class_file_label_checker.sv =====
module class_file_label_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    input  logic        data_ready,
    input  logic [7:0]  data_byte,
    input  logic        start_of_file,
    input  logic        result_valid,
    input  logic        result_ready,
    input  logic [4:0]  section,
    input  logic [15:0] entry_index,
    input  logic [7:0]  pool_tag,
    input  logic        value_done,
    input  logic [31:0] value,
    input  logic        file_done,
    input  logic        parse_error,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CP_INTEGER        = 8'd3;
    localparam logic [7:0] CP_FLOAT          = 8'd4;
    localparam logic [7:0] CP_CLASS          = 8'd7;
    localparam logic [7:0] CP_STRING         = 8'd8;
    localparam logic [7:0] CP_FIELDREF       = 8'd9;
    localparam logic [7:0] CP_METHODREF      = 8'd10;
    localparam logic [7:0] CP_IMETHODREF     = 8'd11;
    localparam logic [7:0] CP_NAME_TYPE      = 8'd12;
    localparam logic [7:0] CP_METHOD_HANDLE  = 8'd15;
    localparam logic [7:0] CP_METHOD_TYPE    = 8'd16;
    localparam logic [7:0] CP_DYNAMIC        = 8'd17;
    localparam logic [7:0] CP_INVOKE_DYNAMIC = 8'd18;
    localparam logic [7:0] CP_MODULE         = 8'd19;
    localparam logic [7:0] CP_PACKAGE        = 8'd20;

    cfsp_pkg::section_t cur_sec;
    logic [2:0]  pos;
    logic [31:0] shift_reg;
    logic [15:0] n_pool;
    logic [15:0] pool_idx;
    logic [7:0]  tag_now;
    logic [31:0] body_left;
    logic [15:0] list_len;
    logic [15:0] list_idx;
    logic [15:0] attr_len;
    logic [15:0] attr_idx;
    logic        err_sticky;
    logic        finished_pulse;
    cfsp_pkg::result_t labels_due[$];
    cfsp_pkg::result_t want;
    cfsp_pkg::result_t got;
    int          mismatches;
    int          results_seen;

    function automatic void reset_parse_state();
        cur_sec        = cfsp_pkg::S_MAGIC;
        pos            = '0;
        shift_reg      = '0;
        n_pool         = '0;
        pool_idx       = 16'd1;
        tag_now        = '0;
        body_left      = '0;
        list_len       = '0;
        list_idx       = '0;
        attr_len       = '0;
        attr_idx       = '0;
        err_sticky     = 1'b0;
        finished_pulse = 1'b0;
    endfunction

    function automatic int fixed_entry_len(input logic [7:0] tg);
        case (tg)
            CP_CLASS, CP_STRING, CP_METHOD_TYPE, CP_MODULE, CP_PACKAGE:
                return 2;
            CP_METHOD_HANDLE:
                return 3;
            CP_INTEGER, CP_FLOAT, CP_FIELDREF, CP_METHODREF, CP_IMETHODREF,
            CP_NAME_TYPE, CP_DYNAMIC, CP_INVOKE_DYNAMIC:
                return 4;
            cfsp_pkg::TAG_LONG, cfsp_pkg::TAG_DOUBLE:
                return 8;
            default:
                return 0;
        endcase
    endfunction

    // count a byte of a field of len bytes; true on its last byte
    function automatic bit take_byte(input int len);
        int c;
        c = pos + 1;
        if (c >= len)
        begin
            pos = '0;
            return 1'b1;
        end
        pos = c[2:0];
        return 1'b0;
    endfunction

    function automatic void advance_pool(input int step);
        int n;
        n = pool_idx + step;
        pos = '0;
        if (n >= n_pool)
        begin
            cur_sec = cfsp_pkg::S_ACCESS;
            tag_now = '0;
        end
        else
        begin
            cur_sec = cfsp_pkg::S_PTAG;
        end
        pool_idx = n[15:0];
    endfunction

    function automatic void open_list(input logic [15:0] count,
                                      input cfsp_pkg::section_t first_sec,
                                      input cfsp_pkg::section_t next_sec);
        list_len = count;
        list_idx = '0;
        cur_sec  = (count == 0) ? next_sec : first_sec;
    endfunction

    function automatic void close_owner(input cfsp_pkg::section_t ahdr);
        if (ahdr == cfsp_pkg::S_CAHDR)
        begin
            cur_sec        = cfsp_pkg::S_END;
            finished_pulse = 1'b1;
        end
        else
        begin
            list_idx = list_idx + 16'd1;
            if (ahdr == cfsp_pkg::S_MAHDR)
                cur_sec = (list_idx >= list_len) ? cfsp_pkg::S_CCOUNT : cfsp_pkg::S_MHDR;
            else
                cur_sec = (list_idx >= list_len) ? cfsp_pkg::S_MCOUNT : cfsp_pkg::S_FHDR;
        end
    endfunction

    function automatic void open_attrs(input logic [15:0] count,
                                       input cfsp_pkg::section_t ahdr);
        attr_len = count;
        attr_idx = '0;
        if (count == 0)
            close_owner(ahdr);
        else
            cur_sec = ahdr;
    endfunction

    function automatic void next_attr(input cfsp_pkg::section_t ahdr);
        attr_idx = attr_idx + 16'd1;
        if (attr_idx >= attr_len)
            close_owner(ahdr);
        else
            cur_sec = ahdr;
    endfunction

    function automatic cfsp_pkg::result_t label_byte(input logic [7:0] b, input logic sof);
        cfsp_pkg::result_t  r;
        cfsp_pkg::section_t sec;
        logic [15:0] idx;
        logic [7:0]  tg;
        logic        vd;
        logic [31:0] val;
        int          c;
        int          len;
        if (sof)
            reset_parse_state();
        finished_pulse = 1'b0;
        sec = cur_sec;
        idx = '0;
        tg  = '0;
        vd  = 1'b0;
        val = '0;
        if (sec != cfsp_pkg::S_END)
            shift_reg = {shift_reg[23:0], b};
        case (sec)
            cfsp_pkg::S_MAGIC:
                if (take_byte(4))
                begin
                    vd      = 1'b1;
                    val     = shift_reg;
                    cur_sec = cfsp_pkg::S_MINOR;
                end
            cfsp_pkg::S_MINOR, cfsp_pkg::S_MAJOR, cfsp_pkg::S_ACCESS,
            cfsp_pkg::S_THIS, cfsp_pkg::S_SUPER:
                if (take_byte(2))
                begin
                    vd      = 1'b1;
                    val     = shift_reg[15:0];
                    cur_sec = cfsp_pkg::section_t'(sec + 1);
                end
            cfsp_pkg::S_PCOUNT:
                if (take_byte(2))
                begin
                    vd       = 1'b1;
                    val      = shift_reg[15:0];
                    n_pool   = shift_reg[15:0];
                    pool_idx = 16'd1;
                    cur_sec  = (n_pool <= 1) ? cfsp_pkg::S_ACCESS : cfsp_pkg::S_PTAG;
                end
            cfsp_pkg::S_PTAG:
            begin
                idx     = pool_idx;
                tg      = b;
                tag_now = b;
                if (b == cfsp_pkg::TAG_UTF8)
                begin
                    body_left = '0;
                    pos       = '0;
                    cur_sec   = cfsp_pkg::S_PBODY;
                end
                else
                begin
                    len = fixed_entry_len(b);
                    if (len == 0)
                    begin
                        err_sticky = 1'b1;
                        advance_pool(1);
                    end
                    else
                    begin
                        body_left = len;
                        pos       = 3'd2;
                        cur_sec   = cfsp_pkg::S_PBODY;
                    end
                end
            end
            cfsp_pkg::S_PBODY:
            begin
                idx = pool_idx;
                tg  = tag_now;
                if (pos < 2)
                begin
                    c = pos + 1;
                    if (c == 2)
                    begin
                        vd        = 1'b1;
                        val       = shift_reg[15:0];
                        body_left = val;
                        pos       = 3'd2;
                        if (val == 0)
                            advance_pool(1);
                    end
                    else
                    begin
                        pos = c[2:0];
                    end
                end
                else if (body_left <= 1)
                begin
                    body_left = '0;
                    advance_pool((tag_now == cfsp_pkg::TAG_LONG ||
                                  tag_now == cfsp_pkg::TAG_DOUBLE) ? 2 : 1);
                end
                else
                begin
                    body_left = body_left - 32'd1;
                end
            end
            cfsp_pkg::S_ICOUNT:
                if (take_byte(2))
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                    open_list(val[15:0], cfsp_pkg::S_IFACE, cfsp_pkg::S_FCOUNT);
                end
            cfsp_pkg::S_IFACE:
            begin
                idx = list_idx;
                if (take_byte(2))
                begin
                    vd       = 1'b1;
                    val      = shift_reg[15:0];
                    list_idx = list_idx + 16'd1;
                    if (list_idx >= list_len)
                        cur_sec = cfsp_pkg::S_FCOUNT;
                end
            end
            cfsp_pkg::S_FCOUNT:
                if (take_byte(2))
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                    open_list(val[15:0], cfsp_pkg::S_FHDR, cfsp_pkg::S_MCOUNT);
                end
            cfsp_pkg::S_MCOUNT:
                if (take_byte(2))
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                    open_list(val[15:0], cfsp_pkg::S_MHDR, cfsp_pkg::S_CCOUNT);
                end
            cfsp_pkg::S_CCOUNT:
                if (take_byte(2))
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                    open_attrs(val[15:0], cfsp_pkg::S_CAHDR);
                end
            cfsp_pkg::S_FHDR, cfsp_pkg::S_MHDR:
            begin
                idx = list_idx;
                c   = pos + 1;
                if (c[0] == 1'b0)
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                end
                if (c >= 8)
                begin
                    pos = '0;
                    open_attrs(val[15:0], cfsp_pkg::section_t'(sec + 1));
                end
                else
                begin
                    pos = c[2:0];
                end
            end
            cfsp_pkg::S_FAHDR, cfsp_pkg::S_MAHDR, cfsp_pkg::S_CAHDR:
            begin
                idx = attr_idx;
                c   = pos + 1;
                if (c == 2)
                begin
                    vd  = 1'b1;
                    val = shift_reg[15:0];
                end
                if (c >= 6)
                begin
                    vd        = 1'b1;
                    val       = shift_reg;
                    pos       = '0;
                    body_left = val;
                    if (val == 0)
                        next_attr(sec);
                    else
                        cur_sec = cfsp_pkg::section_t'(sec + 1);
                end
                else
                begin
                    pos = c[2:0];
                end
            end
            cfsp_pkg::S_FABODY, cfsp_pkg::S_MABODY, cfsp_pkg::S_CABODY:
            begin
                idx = attr_idx;
                if (body_left <= 1)
                begin
                    body_left = '0;
                    next_attr(cfsp_pkg::section_t'(sec - 1));
                end
                else
                begin
                    body_left = body_left - 32'd1;
                end
            end
            default:
            begin
                sec     = cfsp_pkg::S_END;
                cur_sec = cfsp_pkg::S_END;
            end
        endcase
        r.section     = sec;
        r.entry_index = idx;
        r.pool_tag    = tg;
        r.value_done  = vd;
        r.value       = vd ? val : 32'd0;
        r.file_done   = finished_pulse;
        r.parse_error = err_sticky;
        return r;
    endfunction

    function automatic void show(input string what, input cfsp_pkg::result_t r);
        $display("  %s section %0d index %0d tag %0d value_done %0b value %h file_done %0b error %0b",
                 what, r.section, r.entry_index, r.pool_tag, r.value_done, r.value,
                 r.file_done, r.parse_error);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_parse_state();
            labels_due.delete();
            mismatches   = 0;
            results_seen = 0;
            fail_count  <= 0;
            pending     <= 0;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                results_seen++;
                got.section     = cfsp_pkg::section_t'(section);
                got.entry_index = entry_index;
                got.pool_tag    = pool_tag;
                got.value_done  = value_done;
                got.value       = value;
                got.file_done   = file_done;
                got.parse_error = parse_error;
                if (labels_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("%0t: result %0d arrived with nothing pending", $time,
                                 results_seen);
                        show("got     ", got);
                    end
                end
                else
                begin
                    want = labels_due.pop_front();
                    if (got.section !== want.section || got.entry_index !== want.entry_index ||
                        got.pool_tag !== want.pool_tag || got.value_done !== want.value_done ||
                        got.value !== want.value || got.file_done !== want.file_done ||
                        got.parse_error !== want.parse_error)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                        begin
                            $display("%0t: result %0d differs", $time, results_seen);
                            show("expected", want);
                            show("got     ", got);
                        end
                    end
                end
            end
            if (data_valid && data_ready)
                labels_due.push_back(label_byte(data_byte, start_of_file));
            fail_count <= mismatches;
            pending    <= labels_due.size();
        end
    end

endmodule

// ===== bench/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          DIRECTED_ITEMS = 25;
    localparam int          RANDOM_ITEMS   = 880;
    localparam int          IDLE_HEAVY     = 80;
    localparam int          IDLE_BOTH      = 29;
    localparam int          HOLD_AT        = 60;
    localparam int          HOLD_CYCLES    = 150;
    localparam int          QUIET_LIMIT    = 1000;
    localparam int          DRAIN_CYCLES   = 10;
    localparam logic [31:0] CLASS_MAGIC    = 32'hCAFEBABE;

    localparam logic [4:0][7:0] TAGS_BODY2 = {8'd7, 8'd8, 8'd16, 8'd19, 8'd20};
    localparam logic [7:0][7:0] TAGS_BODY4 = {8'd3, 8'd4, 8'd9, 8'd10, 8'd11, 8'd12,
                                              8'd17, 8'd18};
    localparam logic [3:0][7:0] GAP_TAGS   = {8'd0, 8'd2, 8'd13, 8'd14};
    localparam logic [7:0]      TAG_METHOD_HANDLE = 8'd15;
    localparam logic [7:0]      FIRST_FREE_TAG    = 8'd21;

    logic        clk;
    logic        rst_n;
    logic        data_valid;
    logic        data_ready;
    logic [7:0]  data_byte;
    logic        start_of_file;
    logic        result_valid;
    logic        result_ready;
    logic [4:0]  section;
    logic [15:0] entry_index;
    logic [7:0]  pool_tag;
    logic        value_done;
    logic [31:0] value;
    logic        file_done;
    logic        parse_error;
    int          fail_count;
    int          pending;

    logic [8:0]  stim_q[$];
    int          send_idle_pct;
    int          ready_stall_pct;
    int          sent_count;

    class_file_stream_parser_unit DUT (.*);

    class_file_label_checker u_check (.*);

    function automatic void put_byte(input logic [7:0] b);
        stim_q.push_back({1'b0, b});
    endfunction

    function automatic void put_u2(input logic [15:0] v);
        put_byte(v[15:8]);
        put_byte(v[7:0]);
    endfunction

    function automatic void put_u4(input logic [31:0] v);
        put_u2(v[31:16]);
        put_u2(v[15:0]);
    endfunction

    function automatic void put_attrs(input int count);
        int len;
        repeat (count)
        begin
            put_u2(16'($urandom));
            len = ($urandom_range(3) == 0) ? 0 : $urandom_range(5, 1);
            put_u4(32'(len));
            repeat (len) put_byte(8'($urandom));
        end
    endfunction

    function automatic void put_members(input int count);
        int n_attr;
        repeat (count)
        begin
            put_u2(16'($urandom));
            put_u2(16'($urandom));
            put_u2(16'($urandom));
            n_attr = $urandom_range(2);
            put_u2(16'(n_attr));
            put_attrs(n_attr);
        end
    endfunction

    function automatic void put_pool();
        int         n_slots;
        int         slot;
        int         len;
        logic [7:0] tg;
        n_slots = ($urandom_range(5) == 0) ? $urandom_range(1) : $urandom_range(7, 2);
        put_u2(16'(n_slots));
        slot = 1;
        while (slot < n_slots)
        begin
            case ($urandom_range(5))
                0:
                begin
                    put_byte(cfsp_pkg::TAG_UTF8);
                    len = $urandom_range(4);
                    put_u2(16'(len));
                    repeat (len) put_byte(8'($urandom));
                    slot++;
                end
                1:
                begin
                    put_byte(TAGS_BODY2[3'($urandom_range(4))]);
                    repeat (2) put_byte(8'($urandom));
                    slot++;
                end
                2:
                begin
                    put_byte(TAG_METHOD_HANDLE);
                    repeat (3) put_byte(8'($urandom));
                    slot++;
                end
                3:
                begin
                    put_byte(TAGS_BODY4[3'($urandom_range(7))]);
                    repeat (4) put_byte(8'($urandom));
                    slot++;
                end
                4:
                begin
                    put_byte($urandom_range(1) ? cfsp_pkg::TAG_LONG : cfsp_pkg::TAG_DOUBLE);
                    repeat (8) put_byte(8'($urandom));
                    slot += 2;
                end
                default:
                begin
                    if ($urandom_range(3) == 0)
                        tg = GAP_TAGS[2'($urandom_range(3))];
                    else
                        tg = 8'($urandom_range(255, FIRST_FREE_TAG));
                    put_byte(tg);
                    slot++;
                end
            endcase
        end
    endfunction

    function automatic void put_class_file();
        int          n;
        logic [31:0] magic;
        magic = ($urandom_range(3) == 0) ? $urandom : CLASS_MAGIC;
        stim_q.push_back({1'b1, magic[31:24]});
        put_byte(magic[23:16]);
        put_u2(magic[15:0]);
        put_u2(16'($urandom));
        put_u2(16'($urandom));
        put_pool();
        put_u2(16'($urandom));
        put_u2(16'($urandom));
        put_u2(16'($urandom));
        n = $urandom_range(3);
        put_u2(16'(n));
        repeat (n) put_u2(16'($urandom));
        n = $urandom_range(2);
        put_u2(16'(n));
        put_members(n);
        n = $urandom_range(2);
        put_u2(16'(n));
        put_members(n);
        n = $urandom_range(2);
        put_u2(16'(n));
        put_attrs(n);
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
    end

    // sender
    initial
    begin
        int mark;
        int cut;
        int n;
        data_valid    <= 1'b0;
        data_byte     <= '0;
        start_of_file <= 1'b0;
        sent_count      = 0;
        send_idle_pct   = 0;
        ready_stall_pct = 0;

        // smallest file: one-slot pool, empty lists, then a byte past the end
        put_u4(CLASS_MAGIC);
        put_u2(16'h0000);
        put_u2(16'hFFFF);
        put_u2(16'h0001);
        put_u2(16'hFFFF);
        put_u2(16'h0000);
        put_u2(16'hFFFF);
        put_u2(16'h0000);
        put_u2(16'h0000);
        put_u2(16'h0000);
        put_u2(16'h0000);
        put_byte(8'hFF);

        while (stim_q.size() < DIRECTED_ITEMS + RANDOM_ITEMS)
        begin
            mark = stim_q.size();
            if ($urandom_range(7) == 0)
            begin
                n = $urandom_range(30, 8);
                stim_q.push_back({1'b1, 8'($urandom)});
                repeat (n - 1) stim_q.push_back({($urandom_range(15) == 0), 8'($urandom)});
            end
            else
            begin
                put_class_file();
                if ($urandom_range(5) == 0)
                begin
                    cut = $urandom_range(stim_q.size() - 1, mark + 1);
                    while (stim_q.size() > cut) void'(stim_q.pop_back());
                end
                else if ($urandom_range(2) == 0)
                begin
                    repeat ($urandom_range(3, 1)) put_byte(8'($urandom));
                end
            end
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        for (int i = 0; i < stim_q.size(); i++)
        begin
            case ((i * 4) / stim_q.size())
                0:
                begin
                    send_idle_pct   = 0;
                    ready_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct   = IDLE_HEAVY;
                    ready_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct   = 0;
                    ready_stall_pct = IDLE_HEAVY;
                end
                default:
                begin
                    send_idle_pct   = IDLE_BOTH;
                    ready_stall_pct = IDLE_BOTH;
                end
            endcase
            while ($urandom_range(99) < send_idle_pct)
            begin
                data_valid <= 1'b0;
                @(posedge clk);
            end
            data_valid    <= 1'b1;
            data_byte     <= stim_q[i][7:0];
            start_of_file <= stim_q[i][8];
            @(posedge clk);
            while (!data_ready) @(posedge clk);
            sent_count++;
        end
        data_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("class_file_stream_parser_unit test passed");
        else
            $display("class_file_stream_parser_unit test failed");
        $finish;
    end

    // receiver: random stalls plus one long hold-off so the input backs up
    initial
    begin
        int hold_left;
        bit held;
        result_ready <= 1'b0;
        hold_left = 0;
        held      = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                result_ready <= 1'b0;
            end
            else if (!held && sent_count >= HOLD_AT)
            begin
                held      = 1'b1;
                hold_left = HOLD_CYCLES;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= ($urandom_range(99) >= ready_stall_pct);
            end
        end
    end

    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT)
        begin
            @(posedge clk);
            if ((data_valid && data_ready) || (result_valid && result_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("class_file_stream_parser_unit test failed");
        $finish;
    end

endmodule

// ===== class_file_stream_parser_unit.f =====
design/cfsp_pkg.sv
design/cfsp_core.sv
design/class_file_stream_parser_unit.sv
bench/class_file_label_checker.sv
bench/tb.sv
